// ----- design/cftf_pkg.sv -----
// Shared types, frame constants and the CRC byte update for the telemetry framer.
`timescale 1ns / 1ps
package cftf_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_MSB   = 16'h8000;
  localparam logic [BYTE_W-1:0] SYNC0     = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC1     = 8'h55;
  localparam logic [BYTE_W-1:0] VERSION   = 8'h01;
  localparam logic [BYTE_W-1:0] TAG_HDR   = 8'h06;
  localparam logic [BYTE_W-1:0] TAG_0B    = 8'h0B;
  localparam logic [BYTE_W-1:0] TAG_0C    = 8'h0C;
  localparam logic [BYTE_W-1:0] TAG_0D    = 8'h0D;
  localparam logic [BYTE_W-1:0] TRAIL_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] TRAIL_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] VAL_COUNT = 8'h02;
  localparam logic [BYTE_W-1:0] LEN_SER   = 8'h14;
  localparam logic [BYTE_W-1:0] LEN_NET   = 8'h15;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  localparam logic [CNT_W-1:0] SER_LAST   = 5'd28;
  localparam logic [CNT_W-1:0] NET_LAST   = 5'd29;
  localparam logic [CNT_W-1:0] SER_CRC_LO = 5'd25;
  localparam logic [CNT_W-1:0] NET_CRC_HI = 5'd26;

  localparam logic [APB_AW-1:0] REG_VARIANT_ADDR = 3'd0;

  typedef struct packed {
    logic              net;
    logic [DATA_W-1:0] force_bits;
    logic [DATA_W-1:0] temp_bits;
  } frame_req_t;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < BYTE_W; b++) begin
      if ((c & CRC_MSB) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/cftf_if.sv -----
// Request channel interfaces for the telemetry framer input and output.
`timescale 1ns / 1ps
interface cftf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] force_bits;
  logic [63:0] temp_bits;

  modport source (output valid, output force_bits, output temp_bits, input ready);
  modport sink (input valid, input force_bits, input temp_bits, output ready);
endinterface

interface cftf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

// ----- design/cftf_front.sv -----
// Front stage: accept a request and tag it with the frame variant.
`timescale 1ns / 1ps
module cftf_front
  import cftf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              variant,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_force_bits,
  input  logic [DATA_W-1:0] in_temp_bits,
  output logic              push_valid,
  input  logic              push_ready,
  output frame_req_t        push_req
);

  logic       vld_r;
  frame_req_t req_r;

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_req   = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.net        <= variant;
      req_r.force_bits <= in_force_bits;
      req_r.temp_bits  <= in_temp_bits;
    end
  end

endmodule

// ----- design/cftf_queue.sv -----
// Two-entry request queue between the front and back stages.
`timescale 1ns / 1ps
module cftf_queue
  import cftf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_req_t push_req,
  output logic       pop_valid,
  input  logic       pop,
  output frame_req_t head_req
);

  frame_req_t        mem [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r;
  logic [Q_AW-1:0]   rp_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign head_req   = mem[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/cftf_back.sv -----
// Back stage: serialize one frame per request, one byte a cycle while the output is not stalled, with running CRC.
`timescale 1ns / 1ps
module cftf_back
  import cftf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  frame_req_t        head_req,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic              vld_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic              adv;
  logic              is_last;
  logic              in_crc;
  logic [BYTE_W-1:0] cur_byte;
  logic [2:0]        k;
  logic [CNT_W-1:0]  off;

  assign adv     = head_valid && (!vld_r || out_ready);
  assign is_last = head_req.net ? (cnt_r == NET_LAST) : (cnt_r == SER_LAST);
  assign in_crc  = head_req.net ? (cnt_r < NET_CRC_HI) : (cnt_r < SER_CRC_LO);
  assign pop     = adv && is_last;

  always_comb begin
    cur_byte = ZERO_BYTE;
    off      = '0;
    k        = '0;
    if (!head_req.net) begin
      priority if (cnt_r == 5'd0) begin
        cur_byte = SYNC0;
      end else if (cnt_r == 5'd1) begin
        cur_byte = SYNC1;
      end else if (cnt_r == 5'd2) begin
        cur_byte = VERSION;
      end else if (cnt_r == 5'd3) begin
        cur_byte = LEN_SER;
      end else if (cnt_r == 5'd4) begin
        cur_byte = ZERO_BYTE;
      end else if (cnt_r == 5'd5) begin
        cur_byte = TAG_HDR;
      end else if (cnt_r == 5'd6) begin
        cur_byte = TAG_0C;
      end else if (cnt_r < 5'd15) begin
        off      = cnt_r - 5'd7;
        k        = off[2:0];
        cur_byte = head_req.force_bits[{k, 3'b000} +: BYTE_W];
      end else if (cnt_r == 5'd15) begin
        cur_byte = TAG_HDR;
      end else if (cnt_r == 5'd16) begin
        cur_byte = TAG_0D;
      end else if (cnt_r < 5'd25) begin
        off      = cnt_r - 5'd17;
        k        = off[2:0];
        cur_byte = head_req.temp_bits[{k, 3'b000} +: BYTE_W];
      end else if (cnt_r == 5'd25) begin
        cur_byte = crc_r[7:0];
      end else if (cnt_r == 5'd26) begin
        cur_byte = crc_r[15:8];
      end else if (cnt_r == 5'd27) begin
        cur_byte = TRAIL_CR;
      end else begin
        cur_byte = TRAIL_LF;
      end
    end else begin
      priority if (cnt_r == 5'd0) begin
        cur_byte = SYNC0;
      end else if (cnt_r == 5'd1) begin
        cur_byte = SYNC1;
      end else if (cnt_r == 5'd2) begin
        cur_byte = VERSION;
      end else if (cnt_r == 5'd3) begin
        cur_byte = ZERO_BYTE;
      end else if (cnt_r == 5'd4) begin
        cur_byte = LEN_NET;
      end else if (cnt_r == 5'd5) begin
        cur_byte = VAL_COUNT;
      end else if (cnt_r == 5'd6) begin
        cur_byte = TAG_HDR;
      end else if (cnt_r == 5'd7) begin
        cur_byte = TAG_0B;
      end else if (cnt_r < 5'd16) begin
        off      = cnt_r - 5'd8;
        k        = ~off[2:0];
        cur_byte = head_req.force_bits[{k, 3'b000} +: BYTE_W];
      end else if (cnt_r == 5'd16) begin
        cur_byte = TAG_HDR;
      end else if (cnt_r == 5'd17) begin
        cur_byte = TAG_0C;
      end else if (cnt_r < 5'd26) begin
        off      = cnt_r - 5'd18;
        k        = ~off[2:0];
        cur_byte = head_req.temp_bits[{k, 3'b000} +: BYTE_W];
      end else if (cnt_r == 5'd26) begin
        cur_byte = crc_r[15:8];
      end else if (cnt_r == 5'd27) begin
        cur_byte = crc_r[7:0];
      end else if (cnt_r == 5'd28) begin
        cur_byte = TRAIL_CR;
      end else begin
        cur_byte = TRAIL_LF;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    if (adv) begin
      if (is_last) begin
        cnt_nxt = '0;
        crc_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (in_crc) begin
          crc_nxt = crc_update(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      if (adv) begin
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= cur_byte;
      last_r <= is_last;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && last_r |-> byte_r == TRAIL_LF)
    else $error("last byte of frame is not the line feed");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NET_LAST)
    else $error("byte counter out of range");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> cnt_r == '0 && crc_r == '0)
    else $error("frame state not cleared after last byte");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ready |=> vld_r && $stable(byte_r) && $stable(last_r))
    else $error("stalled output byte changed");
`endif

endmodule

// ----- design/crc_framed_telemetry_framer.sv -----
// Top level of the CRC-framed telemetry framer.
`timescale 1ns / 1ps
// Usage:
// Each request on in_ch carries two raw 64-bit double bit patterns (force and
// temperature). The block emits one wire frame per request on out_ch, one byte
// per transfer, with last_byte set on the final 0x0A trailer byte.
// frame_variant (APB register at address 0, bit 0) selects the serial frame
// (29 bytes, little-endian) or the network frame (30 bytes, big-endian).
// The first byte of a frame becomes valid once the input request has passed the
// front register, then the queue write and the output register.
// Throughput: one byte per cycle while out_ch is ready, set by the byte serializer
// in the back stage; frames follow each other with no gap when the next one is queued.
// in_ch stays ready while the front register is free or the queue has room,
// so up to two more requests can wait behind the frame being sent.
// When out_ch stalls, the output byte holds and the serializer waits; the input
// side keeps taking requests until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops any frame in flight
// and returns frame_variant to the serial frame.
module crc_framed_telemetry_framer
  import cftf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cftf_in_if.sink           in_ch,
  cftf_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic       variant_r;
  logic       variant_sel;
  logic       push_valid;
  logic       push_ready;
  frame_req_t push_req;
  logic       head_valid;
  frame_req_t head_req;
  logic       pop;

  assign pready      = 1'b1;
  assign variant_sel = (paddr[APB_AW-1:2] == REG_VARIANT_ADDR[APB_AW-1:2]);
  assign prdata      = variant_sel ? {{(APB_DW-1){1'b0}}, variant_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && variant_sel) begin
      variant_r <= pwdata[0];
    end
  end

  cftf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .variant      (variant_r),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_force_bits(in_ch.force_bits),
    .in_temp_bits (in_ch.temp_bits),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_req     (push_req)
  );

  cftf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_req  (push_req),
    .pop_valid (head_valid),
    .pop       (pop),
    .head_req  (head_req)
  );

  cftf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_req  (head_req),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_byte)
  );

endmodule

// ----- dv/tb_crc_framed_telemetry_framer.sv -----
// Testbench for the telemetry framer: predicts each wire frame byte by byte and checks it.
`timescale 1ns / 1ps
module tb_crc_framed_telemetry_framer;
  import cftf_pkg::*;

  localparam int REG_FRAME_VARIANT = 0;
  localparam int REG_SPARE         = 1;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int RANDOM_PHASES     = 4;
  localparam int PHASE_REQUESTS    = 70;
  localparam int CORNER_COUNT      = 6;

  localparam logic [63:0] CORNER_FORCE [CORNER_COUNT] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF8_0000_0000_0000,
    64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA};
  localparam logic [63:0] CORNER_TEMP [CORNER_COUNT] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
    64'hFFF0_0000_0000_0000, 64'hFEDC_BA98_7654_3210, 64'h5555_5555_5555_5555};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  class telemetry_frame_model;
    bit          network;
    int          mismatches;
    frame_byte_t expected_bytes[$];
    logic [7:0]  frame_bytes[$];

    function void write_register(int index, logic [31:0] value);
      if (index == REG_FRAME_VARIANT) network = value[0];
    endfunction

    function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
      logic feedback;
      for (int b = 7; b >= 0; b--) begin
        feedback = crc[15] ^ data[b];
        crc = {crc[14:0], 1'b0};
        if (feedback) crc = crc ^ CRC_POLY;
      end
      return crc;
    endfunction

    function void add_byte(logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
    endfunction

    function void put_word(logic [63:0] value);
      for (int i = 0; i < 8; i++) begin
        add_byte(network ? value[63 - 8 * i -: 8] : value[8 * i +: 8]);
      end
    endfunction

    function void note_request(logic [63:0] force_val, logic [63:0] temp_val);
      logic [15:0] crc;
      frame_byte_t entry;
      frame_bytes.delete();
      add_byte(SYNC0);
      add_byte(SYNC1);
      add_byte(VERSION);
      if (network) begin
        add_byte(ZERO_BYTE);
        add_byte(LEN_NET);
        add_byte(VAL_COUNT);
        add_byte(TAG_HDR);
        add_byte(TAG_0B);
        put_word(force_val);
        add_byte(TAG_HDR);
        add_byte(TAG_0C);
        put_word(temp_val);
      end else begin
        add_byte(LEN_SER);
        add_byte(ZERO_BYTE);
        add_byte(TAG_HDR);
        add_byte(TAG_0C);
        put_word(force_val);
        add_byte(TAG_HDR);
        add_byte(TAG_0D);
        put_word(temp_val);
      end
      crc = '0;
      foreach (frame_bytes[i]) crc = crc_byte(crc, frame_bytes[i]);
      if (network) begin
        add_byte(crc[15:8]);
        add_byte(crc[7:0]);
      end else begin
        add_byte(crc[7:0]);
        add_byte(crc[15:8]);
      end
      add_byte(TRAIL_CR);
      add_byte(TRAIL_LF);
      foreach (frame_bytes[i]) begin
        entry.data = frame_bytes[i];
        entry.last = (i == frame_bytes.size() - 1);
        expected_bytes.insert(expected_bytes.size(), entry);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte expected none actual %02h", data);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte expected %02h actual %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_byte expected %0b actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic steady = 1'b0;
  int cycle_count = 0;
  int read_faults = 0;

  telemetry_frame_model model = new();

  cftf_in_if  in_ch();
  cftf_out_if out_ch();

  crc_framed_telemetry_framer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      model.note_request(in_ch.force_bits, in_ch.temp_bits);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      model.check_byte(out_ch.out_byte, out_ch.last_byte);
    end
  end

  function automatic logic [63:0] pick_double();
    case ($urandom_range(9))
      0: return CORNER_FORCE[$urandom_range(CORNER_COUNT - 1)];
      1: return CORNER_TEMP[$urandom_range(CORNER_COUNT - 1)];
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_request(input logic [63:0] force_val, input logic [63:0] temp_val);
    while (!steady && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.force_bits <= force_val;
    in_ch.temp_bits  <= temp_val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic reg_write(input int index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(index * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model.write_register(index, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(input int index, input logic want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(index * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== want) begin
      $error("frame_variant expected %0b actual %0b", want, prdata[0]);
      read_faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic variant;
    in_ch.valid      <= 1'b0;
    in_ch.force_bits <= '0;
    in_ch.temp_bits  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_read_check(REG_FRAME_VARIANT, 1'b0);
    for (int i = 0; i < CORNER_COUNT; i++) send_request(CORNER_FORCE[i], CORNER_TEMP[i]);
    in_ch.valid <= 1'b0;
    drain();

    reg_write(REG_FRAME_VARIANT, 32'hFFFF_FFFF);
    reg_read_check(REG_FRAME_VARIANT, 1'b1);
    reg_write(REG_SPARE, 32'h0000_0000);
    reg_read_check(REG_FRAME_VARIANT, 1'b1);
    for (int i = 0; i < CORNER_COUNT; i++) send_request(CORNER_FORCE[i], CORNER_TEMP[i]);
    in_ch.valid <= 1'b0;
    drain();

    reg_write(REG_FRAME_VARIANT, 32'hFFFF_FFFE);
    reg_read_check(REG_FRAME_VARIANT, 1'b0);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_read_check(REG_FRAME_VARIANT, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      variant = (p % 2 == 0);
      reg_write(REG_FRAME_VARIANT, ($urandom() & 32'hFFFF_FFFE) | {31'b0, variant});
      reg_read_check(REG_FRAME_VARIANT, variant);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        steady = (p == 2 && n < 40);
        send_request(pick_double(), pick_double());
      end
      steady = 1'b0;
      in_ch.valid <= 1'b0;
      drain();
    end

    if (model.mismatches == 0 && read_faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
